// ----- rtl/core/box_muller_gaussian_pair_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Box-Muller Gaussian pair generator
// Concurrent checks on clk with asynchronous reset arst_n; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef BOX_MULLER_GAUSSIAN_PAIR_MACROS_SVH
`define BOX_MULLER_GAUSSIAN_PAIR_MACROS_SVH

`ifndef SYNTHESIS
`define BMG_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BMG_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("assertion failed");
`else
`define BMG_ASSERT_IMPL(label, ante, cons)
`define BMG_ASSERT_NEVER(label, expr)
`endif

`endif

// ----- rtl/core/bmg_pkg.sv -----
// ----------------------------------------------------------------------------
// bmg_pkg
// Types, constants and tables shared by the Gaussian pair pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmg_pkg;

	localparam int RAD_W      = 32;
	localparam int ANG_W      = 16;
	localparam int OUT_W      = 16;
	localparam int LOG_FRAC   = 24;
	localparam int NORM_LAT   = 3;
	localparam int LOG_LAT    = NORM_LAT + LOG_FRAC + 2;
	localparam int SQRT_STEPS = 24;
	localparam int SQRT_W     = 48;
	localparam int ROOT_W     = 24;
	localparam int V_W        = 31;
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_LAT = CORDIC_STEPS + 2;
	localparam int FRONT_LAT  = LOG_LAT + SQRT_STEPS;
	localparam int TOTAL_LAT  = FRONT_LAT + CORDIC_LAT;
	localparam int XY_W       = 26;
	localparam int Z_W        = 34;

	localparam logic [30:0] TWO_LN2_Q30     = 31'd1488522236;
	localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;

	localparam logic [31:0] TURN_ATAN [0:CORDIC_STEPS-1] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861
	};

	typedef struct packed {
		logic [RAD_W-1:0] uniform_radius;
		logic [ANG_W-1:0] uniform_angle;
		logic             last_in;
	} in_word_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] normal_cos;
		logic signed [OUT_W-1:0] normal_sin;
		logic                    last_out;
	} out_word_t;

	typedef struct packed {
		logic             valid;
		logic [ANG_W-1:0] angle;
		logic             last;
	} side_t;

endpackage

// ----- rtl/core/bmg_log.sv -----
// ----------------------------------------------------------------------------
// bmg_log
// Pipelined -2 ln(u1) in Q.24: leading-one normalize, squaring log2, scale.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmg_log (
	input  logic                      clk,
	input  logic [bmg_pkg::RAD_W-1:0] radius,
	output logic [bmg_pkg::V_W-1:0]   v
);
	import bmg_pkg::*;

	logic [32:0] n0, n1c, n2c, n3c;
	logic [5:0]  s1c, s2c, s3c;
	logic [32:0] n_s1, n_s2;
	logic [5:0]  sh_s1, sh_s2;
	logic [31:0] x_s [0:LOG_FRAC];
	logic [LOG_FRAC-1:0] f_s [0:LOG_FRAC];
	logic [5:0]  e_s [0:LOG_FRAC];
	logic [29:0] t_s;
	logic [60:0] prod;
	logic [V_W-1:0] v_s;

	assign n0 = {1'b0, radius} + 33'd1;

	always_comb begin
		n1c = n0;
		s1c = '0;
		if (n1c[32:17] == '0) begin
			n1c = n1c << 16;
			s1c = s1c + 6'd16;
		end
		if (n1c[32:25] == '0) begin
			n1c = n1c << 8;
			s1c = s1c + 6'd8;
		end
	end

	always_comb begin
		n2c = n_s1;
		s2c = sh_s1;
		if (n2c[32:29] == '0) begin
			n2c = n2c << 4;
			s2c = s2c + 6'd4;
		end
		if (n2c[32:31] == '0) begin
			n2c = n2c << 2;
			s2c = s2c + 6'd2;
		end
	end

	always_comb begin
		n3c = n_s2;
		s3c = sh_s2;
		if (!n3c[32]) begin
			n3c = n3c << 1;
			s3c = s3c + 6'd1;
		end
		if (!n3c[32]) begin
			n3c = n3c << 1;
			s3c = s3c + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		n_s1  <= n1c;
		sh_s1 <= s1c;
		n_s2  <= n2c;
		sh_s2 <= s2c;
		x_s[0] <= n3c[32:1];
		f_s[0] <= '0;
		e_s[0] <= 6'd32 - s3c;
	end

	for (genvar i = 0; i < LOG_FRAC; i++) begin : g_sq
		logic [63:0] sq;
		logic [32:0] y;
		assign sq = x_s[i] * x_s[i];
		assign y  = sq[63:31];
		always_ff @(posedge clk) begin
			x_s[i+1] <= y[32] ? y[32:1] : y[31:0];
			f_s[i+1] <= {f_s[i][LOG_FRAC-2:0], y[32]};
			e_s[i+1] <= e_s[i];
		end
	end

	assign prod = 61'(t_s) * 61'(TWO_LN2_Q30) + 61'(30'h2000_0000);

	always_ff @(posedge clk) begin
		t_s <= 30'h2000_0000 - {e_s[LOG_FRAC], f_s[LOG_FRAC]};
		v_s <= prod[60:30];
	end

	assign v = v_s;

endmodule

// ----- rtl/core/bmg_sqrt.sv -----
// ----------------------------------------------------------------------------
// bmg_sqrt
// Pipelined integer square root, one result bit per stage: floor(sqrt(v<<16)).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmg_sqrt (
	input  logic                       clk,
	input  logic [bmg_pkg::V_W-1:0]    v,
	output logic [bmg_pkg::ROOT_W-1:0] root
);
	import bmg_pkg::*;

	logic [SQRT_W-1:0] rem_s [1:SQRT_STEPS];
	logic [SQRT_W-1:0] res_s [1:SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (46 - 2 * k);
		logic [SQRT_W-1:0] rem_in;
		logic [SQRT_W-1:0] res_in;
		logic [SQRT_W-1:0] trial;
		if (k == 0) begin : g_first
			assign rem_in = {1'b0, v, 16'b0};
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign res_in = res_s[k];
		end
		assign trial = res_in + BIT;
		always_ff @(posedge clk) begin
			if (rem_in >= trial) begin
				rem_s[k+1] <= rem_in - trial;
				res_s[k+1] <= (res_in >> 1) + BIT;
			end else begin
				rem_s[k+1] <= rem_in;
				res_s[k+1] <= res_in >> 1;
			end
		end
	end

	assign root = res_s[SQRT_STEPS][ROOT_W-1:0];

endmodule

// ----- rtl/core/bmg_cordic.sv -----
// ----------------------------------------------------------------------------
// bmg_cordic
// Gain scale, 16-stage rotation CORDIC, quadrant fold and Q4.12 rounding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmg_cordic (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [bmg_pkg::ROOT_W-1:0] root,
	input  bmg_pkg::side_t             side,
	output logic                       done,
	output bmg_pkg::out_word_t         result
);
	import bmg_pkg::*;

	logic [ANG_W:0]   asum;
	logic [53:0]      gprod;
	logic signed [XY_W-1:0] x_s [0:CORDIC_STEPS];
	logic signed [XY_W-1:0] y_s [0:CORDIC_STEPS];
	logic signed [Z_W-1:0]  z_s [0:CORDIC_STEPS];
	logic [1:0]             q_s [0:CORDIC_STEPS];
	logic                   l_s [0:CORDIC_STEPS];
	logic                   vld_s [0:CORDIC_STEPS];
	logic signed [XY_W-1:0] oc, os;
	out_word_t              res_q;
	logic                   done_q;

	function automatic logic signed [OUT_W-1:0] to_q412(input logic signed [XY_W-1:0] a);
		logic signed [XY_W:0]   b;
		logic signed [XY_W-8:0] c;
		b = {a[XY_W-1], a} + 27'sd128;
		c = b[XY_W:8];
		if (c > 19'sd32767)
			return 16'sh7fff;
		else if (c < -19'sd32768)
			return 16'sh8000;
		else
			return c[OUT_W-1:0];
	endfunction

	assign asum  = {1'b0, side.angle} + 17'd8192;
	assign gprod = 54'(root) * 54'(CORDIC_GAIN_Q30) + 54'(30'h2000_0000);

	always_ff @(posedge clk) begin
		x_s[0] <= XY_W'($signed({2'b00, gprod[53:30]}));
		y_s[0] <= '0;
		z_s[0] <= Z_W'($signed({~asum[13], asum[12:0], 16'b0}));
		q_s[0] <= asum[15:14];
		l_s[0] <= side.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= side.valid;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		logic signed [Z_W-1:0] ang;
		assign ang = Z_W'($signed({1'b0, TURN_ATAN[i]}));
		always_ff @(posedge clk) begin
			if (!z_s[i][Z_W-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ang;
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ang;
			end
			q_s[i+1] <= q_s[i];
			l_s[i+1] <= l_s[i];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
	end

	always_comb begin
		case (q_s[CORDIC_STEPS])
			2'd1: begin
				oc = -y_s[CORDIC_STEPS];
				os = x_s[CORDIC_STEPS];
			end
			2'd2: begin
				oc = -x_s[CORDIC_STEPS];
				os = -y_s[CORDIC_STEPS];
			end
			2'd3: begin
				oc = y_s[CORDIC_STEPS];
				os = -x_s[CORDIC_STEPS];
			end
			default: begin
				oc = x_s[CORDIC_STEPS];
				os = y_s[CORDIC_STEPS];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		res_q.normal_cos <= to_q412(oc);
		res_q.normal_sin <= to_q412(os);
		res_q.last_out   <= l_s[CORDIC_STEPS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[CORDIC_STEPS];
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ----- rtl/core/box_muller_gaussian_pair.sv -----
// ----------------------------------------------------------------------------
// box_muller_gaussian_pair
// An accepted word passes through the log, the square root and the CORDIC
// with gain and output rounding, in that order, to its done strobe.
// Throughput: one word per cycle; busy stays low, every stage is a register.
// Reset: arst_n clears the valid bits only; the datapath is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "box_muller_gaussian_pair_macros.svh"

module box_muller_gaussian_pair (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  bmg_pkg::in_word_t   sample,
	output logic                done,
	output bmg_pkg::out_word_t  result
);
	import bmg_pkg::*;

	logic [V_W-1:0]    v;
	logic [ROOT_W-1:0] root;
	logic              vld_s [0:FRONT_LAT-1];
	logic [ANG_W-1:0]  ang_s [0:FRONT_LAT-1];
	logic              last_s [0:FRONT_LAT-1];
	side_t             side;

	assign busy = 1'b0;

	bmg_log u_log (
		.clk    (clk),
		.radius (sample.uniform_radius),
		.v      (v)
	);

	bmg_sqrt u_sqrt (
		.clk  (clk),
		.v    (v),
		.root (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ang_s[0]  <= sample.uniform_angle;
		last_s[0] <= sample.last_in;
	end

	for (genvar i = 1; i < FRONT_LAT; i++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vld_s[i-1];
			end
		end
		always_ff @(posedge clk) begin
			ang_s[i]  <= ang_s[i-1];
			last_s[i] <= last_s[i-1];
		end
	end

	assign side.valid = vld_s[FRONT_LAT-1];
	assign side.angle = ang_s[FRONT_LAT-1];
	assign side.last  = last_s[FRONT_LAT-1];

	bmg_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.root   (root),
		.side   (side),
		.done   (done),
		.result (result)
	);

	`BMG_ASSERT_IMPL(a_done_latency, done, $past(start, TOTAL_LAT))
	`BMG_ASSERT_IMPL(a_last_follows, done, result.last_out == $past(sample.last_in, TOTAL_LAT))
	`BMG_ASSERT_IMPL(a_zero_radius, done && ($past(sample.uniform_radius, TOTAL_LAT) == '1), result.normal_cos == '0 && result.normal_sin == '0)
	`BMG_ASSERT_NEVER(a_never_busy, busy)

endmodule
